// File: rtl/core/llp_pkg.sv
// Shared types and constants for the LL(1) predictive parse engine.
// Used by llp_ctrl, llp_dpath and ll1_predictive_parse_engine; no dependencies.
package llp_pkg;

   // Request opcodes
   localparam logic [1:0] OP_TABLE_WR = 2'd0;
   localparam logic [1:0] OP_PROD_WR  = 2'd1;
   localparam logic [1:0] OP_START    = 2'd2;
   localparam logic [1:0] OP_TOKEN    = 2'd3;

   // Result kinds
   localparam logic [2:0] KIND_EXPAND   = 3'd0;
   localparam logic [2:0] KIND_CONSUMED = 3'd1;
   localparam logic [2:0] KIND_ACCEPTED = 3'd2;
   localparam logic [2:0] KIND_ERROR    = 3'd3;
   localparam logic [2:0] KIND_DONE     = 3'd4;

   // Error codes
   localparam logic [2:0] ERR_NONE     = 3'd0;
   localparam logic [2:0] ERR_NO_ENTRY = 3'd1;
   localparam logic [2:0] ERR_MISMATCH = 3'd2;
   localparam logic [2:0] ERR_OVERFLOW = 3'd3;
   localparam logic [2:0] ERR_EXP_LIM  = 3'd4;
   localparam logic [2:0] ERR_NOT_PARS = 3'd5;

   // CSR indexes
   localparam logic CSR_START_NT = 1'b0;
   localparam logic CSR_END_TERM = 1'b1;

   // Grammar geometry, fixed by the field widths
   localparam int unsigned MAX_RHS_LENGTH = 8;
   localparam int unsigned TABLE_WORDS    = 512;
   localparam int unsigned PROD_WORDS     = 64;

   typedef enum logic [1:0] {
      MODE_IDLE, MODE_PARSING, MODE_ACCEPTED, MODE_ERROR
   } mode_type;

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_START2, ST_TOP, ST_LOOK, ST_PROD, ST_LEN,
      ST_RREAD, ST_RWRITE
   } state_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic       clr;
      logic       latch;
      logic       tbl_wr;
      logic       prod_wr;
      logic       push_end;
      logic       push_start;
      logic       rd_top;
      logic       rd_tbl;
      logic       rd_len;
      logic       pop;
      logic       load_k;
      logic       rd_sym;
      logic       wr_sym;
      logic       exp_inc;
      logic       emit;
      logic [2:0] emit_kind;
      logic [2:0] emit_err;
      logic       emit_last;
      logic       set_mode;
      mode_type   mode;
   } cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic clr_last;
      logic parsing;
      logic sp_zero;
      logic top_is_nt;
      logic top_match;
      logic tok_is_end;
      logic nt_in_range;
      logic prod_zero;
      logic exp_limit;
      logic overflow;
      logic k_zero;
   } sts_type;

endpackage

// File: rtl/core/ll1_predictive_parse_engine.sv
// Top level of the LL(1) table-driven predictive parse engine.
// Depends on llp_pkg, llp_ctrl and llp_dpath.

// Table-driven LL(1) parser. A request is taken when start is high and busy is
// low. Table writes, production writes and token requests while not parsing
// answer from the idle state; a start request pushes the end terminal, then
// the start nonterminal. A token request reads the stack top and answers on a
// terminal match; an expansion reads the table, the production length and each
// right-hand-side symbol, pushing it, since each step is one access to the
// single-port stack, table, length or symbol memory. Each result shows on the
// rsp_ ports for one cycle with rsp_valid high and cannot be stalled; rsp_last
// marks the final result of a request. After reset the parse table and
// production lengths are cleared with busy high; CSR writes are taken always.
module ll1_predictive_parse_engine #(
   parameter int unsigned STACK_DEPTH    = 64,
   parameter int unsigned MAX_EXPANSIONS = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [1:0] req_opcode,
   input  logic [3:0] req_nonterminal,
   input  logic [4:0] req_terminal,
   input  logic [5:0] req_prod_index,
   input  logic [2:0] req_position,
   input  logic [3:0] req_prod_length,
   input  logic       req_sym_is_nonterminal,
   input  logic [4:0] req_sym_index,
   input  logic       csr_we,
   input  logic       csr_index,
   input  logic [4:0] csr_wdata,
   output logic       rsp_valid,
   output logic [2:0] rsp_kind,
   output logic [5:0] rsp_production,
   output logic [2:0] rsp_error_code,
   output logic [6:0] rsp_stack_depth,
   output logic       rsp_last
);

   llp_pkg::cmd_type cmd;
   llp_pkg::sts_type sts;

   // Controller
   llp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_opcode (req_opcode),
      .sts        (sts),
      .cmd        (cmd),
      .busy       (busy)
   );

   // Datapath
   llp_dpath #(
      .STACK_DEPTH    (STACK_DEPTH),
      .MAX_EXPANSIONS (MAX_EXPANSIONS)
   ) u_dpath (
      .clock                  (clock),
      .reset                  (reset),
      .cmd                    (cmd),
      .sts                    (sts),
      .req_nonterminal        (req_nonterminal),
      .req_terminal           (req_terminal),
      .req_prod_index         (req_prod_index),
      .req_position           (req_position),
      .req_prod_length        (req_prod_length),
      .req_sym_is_nonterminal (req_sym_is_nonterminal),
      .req_sym_index          (req_sym_index),
      .csr_we                 (csr_we),
      .csr_index              (csr_index),
      .csr_wdata              (csr_wdata),
      .rsp_valid              (rsp_valid),
      .rsp_kind               (rsp_kind),
      .rsp_production         (rsp_production),
      .rsp_error_code         (rsp_error_code),
      .rsp_stack_depth        (rsp_stack_depth),
      .rsp_last               (rsp_last)
   );

`ifndef SYNTHESIS
   // An expansion is never the final result of a token
   a_expand_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == llp_pkg::KIND_EXPAND |-> !rsp_last)
      else $error("expansion marked last");

   // Errors always end the transaction
   a_error_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == llp_pkg::KIND_ERROR |-> rsp_last)
      else $error("error result not last");

   // A final result is never followed by another one before a new request
   a_last_then_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last && !(start && !busy) |=> !rsp_valid)
      else $error("result after last without request");

   // Error code only accompanies error results
   a_err_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != llp_pkg::KIND_ERROR |-> rsp_error_code == llp_pkg::ERR_NONE)
      else $error("error code on non-error result");
`endif

endmodule

// File: rtl/core/llp_dpath.sv
// Datapath of the LL(1) parse engine: tables, parse stack, counters, result register.
// Depends on llp_pkg; driven by llp_ctrl through llp_pkg::cmd_type.
module llp_dpath #(
   parameter int unsigned STACK_DEPTH    = 64,
   parameter int unsigned MAX_EXPANSIONS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  llp_pkg::cmd_type     cmd,
   output llp_pkg::sts_type     sts,
   input  logic [3:0]           req_nonterminal,
   input  logic [4:0]           req_terminal,
   input  logic [5:0]           req_prod_index,
   input  logic [2:0]           req_position,
   input  logic [3:0]           req_prod_length,
   input  logic                 req_sym_is_nonterminal,
   input  logic [4:0]           req_sym_index,
   input  logic                 csr_we,
   input  logic                 csr_index,
   input  logic [4:0]           csr_wdata,
   output logic                 rsp_valid,
   output logic [2:0]           rsp_kind,
   output logic [5:0]           rsp_production,
   output logic [2:0]           rsp_error_code,
   output logic [6:0]           rsp_stack_depth,
   output logic                 rsp_last
);

   localparam int unsigned AW  = $clog2(STACK_DEPTH);
   localparam int unsigned SPW = $clog2(STACK_DEPTH + 1);
   localparam int unsigned EW  = $clog2(MAX_EXPANSIONS + 1);

   // Memories
   logic [5:0] stack_mem [STACK_DEPTH];
   logic [5:0] table_mem [llp_pkg::TABLE_WORDS];
   logic [3:0] len_mem   [llp_pkg::PROD_WORDS];
   logic [5:0] sym_mem   [llp_pkg::TABLE_WORDS];

   // Registers
   logic [3:0]        start_nt_ff;
   logic [4:0]        end_term_ff;
   llp_pkg::mode_type mode_ff;
   logic [SPW-1:0]    sp_ff, sp_in;
   logic [8:0]        clr_ff;
   logic [4:0]        tok_ff;
   logic [5:0]        top_ff;
   logic [5:0]        p_ff;
   logic [3:0]        len_ff;
   logic [3:0]        k_ff;
   logic [5:0]        symr_ff;
   logic [EW-1:0]     exp_ff;
   logic              rsp_valid_ff;
   logic [2:0]        rsp_kind_ff, rsp_err_ff;
   logic [5:0]        rsp_prod_ff;
   logic [6:0]        rsp_depth_ff;
   logic              rsp_last_ff;

   logic [3:0]        plen_sat;
   logic [AW-1:0]     st_waddr;
   logic [5:0]        st_wdata;
   logic              st_we;
   logic [SPW:0]      grow;
   logic [2:0]        k_dec;

   // CSRs
   always_ff @(posedge clock) begin
      if (reset) begin
         start_nt_ff <= 4'd0;
         end_term_ff <= 5'd31;
      end else if (csr_we) begin
         case (csr_index)
            llp_pkg::CSR_START_NT: start_nt_ff <= csr_wdata[3:0];
            llp_pkg::CSR_END_TERM: end_term_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Stack pointer next value
   always_comb begin
      sp_in = sp_ff;
      if (cmd.push_start)
         sp_in = SPW'(2);
      else if (cmd.pop)
         sp_in = sp_ff - SPW'(1);
      else if (cmd.wr_sym)
         sp_in = sp_ff + SPW'(1);
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         sp_ff        <= '0;
         mode_ff      <= llp_pkg::MODE_IDLE;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sp_ff        <= sp_in;
         rsp_valid_ff <= cmd.emit;
         if (cmd.set_mode)
            mode_ff <= cmd.mode;
         if (cmd.clr)
            clr_ff <= clr_ff + 9'd1;
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         tok_ff <= req_terminal;
         exp_ff <= '0;
      end else if (cmd.exp_inc) begin
         exp_ff <= exp_ff + EW'(1);
      end
      if (cmd.load_k)
         k_ff <= len_ff;
      else if (cmd.wr_sym)
         k_ff <= k_ff - 4'd1;
   end

   // Result register
   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_kind_ff  <= cmd.emit_kind;
         rsp_err_ff   <= cmd.emit_err;
         rsp_last_ff  <= cmd.emit_last;
         rsp_prod_ff  <= (cmd.emit_kind == llp_pkg::KIND_EXPAND) ? p_ff : 6'd0;
         rsp_depth_ff <= 7'(sp_in);
      end
   end

   // Parse stack memory, one write port
   always_comb begin
      st_we    = cmd.push_end | cmd.push_start | cmd.wr_sym;
      st_waddr = sp_ff[AW-1:0];
      st_wdata = symr_ff;
      if (cmd.push_end) begin
         st_waddr = AW'(0);
         st_wdata = {1'b0, end_term_ff};
      end else if (cmd.push_start) begin
         st_waddr = AW'(1);
         st_wdata = {2'b10, start_nt_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (st_we)
         stack_mem[st_waddr] <= st_wdata;
      if (cmd.rd_top)
         top_ff <= stack_mem[AW'(sp_ff - SPW'(1))];
   end

   // Parse table, cleared after reset
   always_ff @(posedge clock) begin
      if (cmd.clr)
         table_mem[clr_ff] <= 6'd0;
      else if (cmd.tbl_wr)
         table_mem[{req_nonterminal, req_terminal}] <= req_prod_index;
      if (cmd.rd_tbl)
         p_ff <= table_mem[{top_ff[3:0], tok_ff}];
   end

   // Production lengths, cleared after reset
   assign plen_sat = (req_prod_length > 4'(llp_pkg::MAX_RHS_LENGTH))
                     ? 4'(llp_pkg::MAX_RHS_LENGTH) : req_prod_length;

   always_ff @(posedge clock) begin
      if (cmd.clr)
         len_mem[clr_ff[5:0]] <= 4'd0;
      else if (cmd.prod_wr)
         len_mem[req_prod_index] <= plen_sat;
      if (cmd.rd_len)
         len_ff <= len_mem[p_ff];
   end

   // Right-hand side symbols
   assign k_dec = 3'(k_ff - 4'd1);

   always_ff @(posedge clock) begin
      if (cmd.prod_wr)
         sym_mem[{req_prod_index, req_position}] <= {req_sym_is_nonterminal, req_sym_index};
      if (cmd.rd_sym)
         symr_ff <= sym_mem[{p_ff, k_dec}];
   end

   // Status
   assign grow = {1'b0, sp_ff} - (SPW+1)'(1) + (SPW+1)'(len_ff);

   always_comb begin
      sts.clr_last    = &clr_ff;
      sts.parsing     = (mode_ff == llp_pkg::MODE_PARSING);
      sts.sp_zero     = (sp_ff == '0);
      sts.top_is_nt   = top_ff[5];
      sts.top_match   = (top_ff[4:0] == tok_ff);
      sts.tok_is_end  = (tok_ff == end_term_ff);
      sts.nt_in_range = ~top_ff[4];
      sts.prod_zero   = (p_ff == 6'd0);
      sts.exp_limit   = (exp_ff >= EW'(MAX_EXPANSIONS));
      sts.overflow    = (grow > (SPW+1)'(STACK_DEPTH));
      sts.k_zero      = (k_ff == 4'd0);
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kind        = rsp_kind_ff;
   assign rsp_production  = rsp_prod_ff;
   assign rsp_error_code  = rsp_err_ff;
   assign rsp_stack_depth = rsp_depth_ff;
   assign rsp_last        = rsp_last_ff;

endmodule

// File: rtl/core/llp_ctrl.sv
// Controller state machine of the LL(1) parse engine.
// Depends on llp_pkg; commands llp_dpath through llp_pkg::cmd_type.
module llp_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [1:0]       req_opcode,
   input  llp_pkg::sts_type sts,
   output llp_pkg::cmd_type cmd,
   output logic             busy
);

   llp_pkg::state_type state_ff, state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset)
         state_ff <= llp_pkg::ST_CLEAR;
      else
         state_ff <= state_in;
   end

   assign busy = (state_ff != llp_pkg::ST_IDLE);

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.mode = llp_pkg::MODE_ERROR;
      case (state_ff)
         llp_pkg::ST_CLEAR: begin
            cmd.clr = 1'b1;
            if (sts.clr_last)
               state_in = llp_pkg::ST_IDLE;
         end
         llp_pkg::ST_IDLE: begin
            if (start) begin
               cmd.emit_last = 1'b1;
               case (req_opcode)
                  llp_pkg::OP_TABLE_WR: begin
                     cmd.tbl_wr    = 1'b1;
                     cmd.emit      = 1'b1;
                     cmd.emit_kind = llp_pkg::KIND_DONE;
                  end
                  llp_pkg::OP_PROD_WR: begin
                     cmd.prod_wr   = 1'b1;
                     cmd.emit      = 1'b1;
                     cmd.emit_kind = llp_pkg::KIND_DONE;
                  end
                  llp_pkg::OP_START: begin
                     cmd.push_end = 1'b1;
                     state_in     = llp_pkg::ST_START2;
                  end
                  default: begin
                     if (sts.parsing) begin
                        cmd.latch = 1'b1;
                        state_in  = llp_pkg::ST_TOP;
                     end else begin
                        cmd.emit      = 1'b1;
                        cmd.emit_kind = llp_pkg::KIND_ERROR;
                        cmd.emit_err  = llp_pkg::ERR_NOT_PARS;
                     end
                  end
               endcase
            end
         end
         llp_pkg::ST_START2: begin
            cmd.push_start = 1'b1;
            cmd.set_mode   = 1'b1;
            cmd.mode       = llp_pkg::MODE_PARSING;
            cmd.emit       = 1'b1;
            cmd.emit_kind  = llp_pkg::KIND_DONE;
            cmd.emit_last  = 1'b1;
            state_in       = llp_pkg::ST_IDLE;
         end
         llp_pkg::ST_TOP: begin
            if (sts.sp_zero) begin
               cmd.emit     = 1'b1;
               cmd.emit_err = llp_pkg::ERR_MISMATCH;
            end else begin
               cmd.rd_top = 1'b1;
               state_in   = llp_pkg::ST_LOOK;
            end
         end
         llp_pkg::ST_LOOK: begin
            if (!sts.top_is_nt) begin
               if (!sts.top_match) begin
                  cmd.emit     = 1'b1;
                  cmd.emit_err = llp_pkg::ERR_MISMATCH;
               end else begin
                  cmd.pop       = 1'b1;
                  cmd.emit      = 1'b1;
                  cmd.emit_last = 1'b1;
                  state_in      = llp_pkg::ST_IDLE;
                  if (sts.tok_is_end) begin
                     cmd.emit_kind = llp_pkg::KIND_ACCEPTED;
                     cmd.set_mode  = 1'b1;
                     cmd.mode      = llp_pkg::MODE_ACCEPTED;
                  end else begin
                     cmd.emit_kind = llp_pkg::KIND_CONSUMED;
                  end
               end
            end else if (!sts.nt_in_range) begin
               cmd.emit     = 1'b1;
               cmd.emit_err = llp_pkg::ERR_NO_ENTRY;
            end else begin
               cmd.rd_tbl = 1'b1;
               state_in   = llp_pkg::ST_PROD;
            end
         end
         llp_pkg::ST_PROD: begin
            if (sts.prod_zero) begin
               cmd.emit     = 1'b1;
               cmd.emit_err = llp_pkg::ERR_NO_ENTRY;
            end else if (sts.exp_limit) begin
               cmd.emit     = 1'b1;
               cmd.emit_err = llp_pkg::ERR_EXP_LIM;
            end else begin
               cmd.rd_len = 1'b1;
               state_in   = llp_pkg::ST_LEN;
            end
         end
         llp_pkg::ST_LEN: begin
            if (sts.overflow) begin
               cmd.emit     = 1'b1;
               cmd.emit_err = llp_pkg::ERR_OVERFLOW;
            end else begin
               cmd.pop    = 1'b1;
               cmd.load_k = 1'b1;
               state_in   = llp_pkg::ST_RREAD;
            end
         end
         llp_pkg::ST_RREAD: begin
            if (sts.k_zero) begin
               cmd.emit      = 1'b1;
               cmd.emit_kind = llp_pkg::KIND_EXPAND;
               cmd.exp_inc   = 1'b1;
               state_in      = llp_pkg::ST_TOP;
            end else begin
               cmd.rd_sym = 1'b1;
               state_in   = llp_pkg::ST_RWRITE;
            end
         end
         llp_pkg::ST_RWRITE: begin
            cmd.wr_sym = 1'b1;
            state_in   = llp_pkg::ST_RREAD;
         end
         default: state_in = llp_pkg::ST_IDLE;
      endcase
      // Any error result ends the token and stops the parse
      if (cmd.emit && cmd.emit_err != llp_pkg::ERR_NONE) begin
         cmd.emit_kind = llp_pkg::KIND_ERROR;
         cmd.emit_last = 1'b1;
         if (cmd.emit_err != llp_pkg::ERR_NOT_PARS) begin
            cmd.set_mode = 1'b1;
            cmd.mode     = llp_pkg::MODE_ERROR;
            state_in     = llp_pkg::ST_IDLE;
         end
      end
   end

endmodule
